FILE: rtl/gsfc_pkg.sv
// Shared types and constants of the gimbal servo frame commander.
// Holds the register set, the frame job record and the fixed-point helpers.
// Has no dependencies; every other file imports it.
package gsfc_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_SERVO_IDS    = 3'd0,
    REG_ONLINE_MASK  = 3'd1,
    REG_IDLE_STOP    = 3'd2,
    REG_ANGLE_EPS    = 3'd3,
    REG_UPDATE_PER   = 3'd4,
    REG_MOVE_TIME    = 3'd5,
    REG_YAW_LIMITS   = 3'd6,
    REG_PITCH_LIMITS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] servo_ids;
    logic [1:0]  online_mask;
    logic [15:0] idle_stop_ticks;
    logic [14:0] angle_epsilon;
    logic [15:0] update_period_ms;
    logic [15:0] move_time_ms;
    logic [31:0] yaw_limits;
    logic [31:0] pitch_limits;
  } cfg_t;

  localparam int RAW_W = 10;

  // One queued tick: which frames to send and the encoded positions
  typedef struct packed {
    logic             yaw_act;
    logic             pitch_act;
    logic             is_stop;
    logic [RAW_W-1:0] yaw_raw;
    logic [RAW_W-1:0] pitch_raw;
  } job_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Frame bytes
  localparam logic [7:0] FRAME_HEAD = 8'h55;
  localparam logic [7:0] CMD_STOP   = 8'd12;
  localparam logic [7:0] CMD_MOVE   = 8'd1;
  localparam logic [7:0] LEN_STOP   = 8'd3;
  localparam logic [7:0] LEN_MOVE   = 8'd7;

  // Byte positions within a frame
  localparam logic [3:0] POS_HEAD0    = 4'd0;
  localparam logic [3:0] POS_HEAD1    = 4'd1;
  localparam logic [3:0] POS_ID       = 4'd2;
  localparam logic [3:0] POS_LEN      = 4'd3;
  localparam logic [3:0] POS_CMD      = 4'd4;
  localparam logic [3:0] POS_P0       = 4'd5;
  localparam logic [3:0] POS_P1       = 4'd6;
  localparam logic [3:0] POS_P2       = 4'd7;
  localparam logic [3:0] POS_P3       = 4'd8;
  localparam logic [3:0] POS_MOVE_CHK = 4'd9;
  localparam logic [3:0] POS_STOP_CHK = 4'd5;

  // Servo angle mapping, in 1/64 degree
  localparam int YAW_OFFSET   = 7680;
  localparam int PITCH_OFFSET = 5760;
  localparam int SERVO_MAX    = 15360;

  // Step scaling: delta * 6/5 (yaw) or 4/5 (pitch), ties away from zero
  localparam logic [2:0] YAW_MUL   = 3'd6;
  localparam logic [2:0] PITCH_MUL = 3'd4;
  localparam int STEP_W      = 19;
  localparam int DIV5_SHIFT  = 20;
  localparam logic [19:0] DIV5_MAGIC = 20'd209716;  // ceil(2^20 / 5)
  localparam int DIV5_PROD_W = STEP_W + DIV5_SHIFT + 1;

  // Divide by five through a reciprocal multiply (exact below 2^18)
  function automatic logic signed [STEP_W-1:0] scale_round(
      input logic signed [15:0] d, input logic [2:0] mul);
    logic signed [16:0]     dx;
    logic [16:0]            dmag;
    logic [STEP_W-1:0]      x;
    logic [DIV5_PROD_W-1:0] prod;
    logic [STEP_W-1:0]      q;
    dx   = 17'(d);
    dmag = dx[16] ? 17'(-dx) : 17'(dx);
    x    = STEP_W'(dmag) * STEP_W'(mul) + STEP_W'(2);
    prod = DIV5_PROD_W'(x) * DIV5_PROD_W'(DIV5_MAGIC);
    q    = STEP_W'(prod >> DIV5_SHIFT);
    return dx[16] ? $signed(-q) : $signed(q);
  endfunction

endpackage

FILE: rtl/gimbal_servo_frame_commander.sv
// Gimbal servo frame commander: ticks in, servo bus frame bytes out.
// A tick passes the stage 1, stage 2, queue and output registers to its first byte.
// Throughput: one tick per cycle while the 4-entry job queue has room; the output
// sends one byte per cycle while out_tready is high, 6 to 20 bytes per sent tick.
// Reset (rst_n low, synchronous): control state cleared, registers to defaults.
module gimbal_servo_frame_commander #(
  parameter int ANGLE_WIDTH      = 16,
  parameter int IDLE_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] remote_sequence, [47:32] yaw_delta, [63:48] pitch_delta,
  // [95:64] now_ms
  input  logic [95:0] in_tdata,
  // [0] source_known
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] frame_byte
  output logic [7:0]  out_tdata,
  // [0] servo_select, [1] frame_end
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gsfc_pkg::*;

  cfg_t  cfg_r;
  job_t  push_job, head_job;
  logic  push, pop, q_empty;
  logic [QCNT_W-1:0] q_count;

  // Register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_ids        <= 16'd513;
      cfg_r.online_mask      <= 2'd0;
      cfg_r.idle_stop_ticks  <= 16'd250;
      cfg_r.angle_epsilon    <= 15'd32;
      cfg_r.update_period_ms <= 16'd20;
      cfg_r.move_time_ms     <= 16'd20;
      cfg_r.yaw_limits       <= 32'd503374336;
      cfg_r.pitch_limits     <= 32'd377547136;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SERVO_IDS:    cfg_r.servo_ids        <= cfg_data[15:0];
        REG_ONLINE_MASK:  cfg_r.online_mask      <= cfg_data[1:0];
        REG_IDLE_STOP:    cfg_r.idle_stop_ticks  <= cfg_data[15:0];
        REG_ANGLE_EPS:    cfg_r.angle_epsilon    <= cfg_data[14:0];
        REG_UPDATE_PER:   cfg_r.update_period_ms <= cfg_data[15:0];
        REG_MOVE_TIME:    cfg_r.move_time_ms     <= cfg_data[15:0];
        REG_YAW_LIMITS:   cfg_r.yaw_limits       <= cfg_data;
        REG_PITCH_LIMITS: cfg_r.pitch_limits     <= cfg_data;
        default: ;
      endcase
    end
  end

  gsfc_front #(
    .ANGLE_WIDTH      (ANGLE_WIDTH),
    .IDLE_COUNT_WIDTH (IDLE_COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_seq   (in_tdata[31:0]),
    .in_known (in_tuser),
    .in_yaw   ($signed(in_tdata[47:32])),
    .in_pitch ($signed(in_tdata[63:48])),
    .in_now   (in_tdata[95:64]),
    .q_count  (q_count),
    .push     (push),
    .push_job (push_job)
  );

  gsfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .count    (q_count)
  );

  gsfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .job           (head_job),
    .job_empty     (q_empty),
    .job_pop       (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_sel       (out_tuser[0]),
    .out_byte      (out_tdata),
    .out_frame_end (out_tuser[1]),
    .out_last      (out_tlast)
  );

endmodule

FILE: rtl/gsfc_front.sv
// Front end of the gimbal servo frame commander: takes ticks, updates the
// control state and queues one frame job per tick that sends anything.
// Depends on gsfc_pkg.
module gsfc_front #(
  parameter int ANGLE_WIDTH      = 16,
  parameter int IDLE_COUNT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gsfc_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  in_seq,
  input  logic                         in_known,
  input  logic signed [15:0]           in_yaw,
  input  logic signed [15:0]           in_pitch,
  input  logic [31:0]                  in_now,
  input  logic [gsfc_pkg::QCNT_W-1:0]  q_count,
  output logic                         push,
  output gsfc_pkg::job_t               push_job
);
  import gsfc_pkg::*;

  localparam int AW  = ANGLE_WIDTH;
  localparam int IW  = IDLE_COUNT_WIDTH;
  localparam int VW  = ((AW > STEP_W) ? AW : STEP_W) + 2;
  localparam int DW  = ((AW + 2) > 16) ? (AW + 2) : 16;
  localparam int CW  = (IW > 16) ? IW : 16;
  localparam int AX  = ((AW > 15) ? AW : 15) + 1;
  localparam int CNT_SUM_W = QCNT_W + 1;

  // Add a step, clamp to the limits, then to the signed angle range
  function automatic logic signed [AW-1:0] next_tgt(
      input logic signed [AW-1:0] cur, input logic signed [STEP_W-1:0] step,
      input logic [31:0] lim);
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] amax;
    logic signed [VW-1:0] amin;
    v    = VW'(cur) + VW'(step);
    lo   = VW'($signed(lim[15:0]));
    hi   = VW'($signed(lim[31:16]));
    amax = VW'({1'b0, {(AW-1){1'b1}}});
    amin = -amax - VW'(1);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    if (v > amax) v = amax;
    if (v < amin) v = amin;
    return AW'(v);
  endfunction

  // Map a target to servo units: round(angle * 1000 / 240 deg)
  function automatic logic [RAW_W-1:0] raw_of(
      input logic signed [AW-1:0] t, input logic signed [AX-1:0] off);
    logic signed [AX-1:0] a;
    logic [13:0]          c;
    logic [19:0]          y;
    logic [11:0]          z;
    logic [23:0]          p;
    a = AX'(t) + off;
    if (a < 0) c = '0;
    else if (a > AX'(SERVO_MAX)) c = 14'(SERVO_MAX);
    else c = a[13:0];
    y = 20'(c) * 20'd50 + 20'd384;
    z = y[19:8];
    // divide by three with a reciprocal, exact below 2^13
    p = 24'(z) * 24'd2731;
    return p[13 +: RAW_W];
  endfunction

  localparam logic signed [AX-1:0] YAW_OFF   = AX'(YAW_OFFSET);
  localparam logic signed [AX-1:0] PITCH_OFF = AX'(PITCH_OFFSET);

  // Stage 1 registers: tick with scaled steps
  logic                     s1_v_r;
  logic [31:0]              s1_seq_r;
  logic                     s1_known_r;
  logic signed [STEP_W-1:0] s1_ystep_r;
  logic signed [STEP_W-1:0] s1_pstep_r;
  logic [31:0]              s1_now_r;

  // Stage 2 registers: decided frames for the tick
  logic                 s2_v_r;
  logic                 s2_ya_r;
  logic                 s2_pa_r;
  logic                 s2_stop_r;
  logic signed [AW-1:0] s2_yt_r;
  logic signed [AW-1:0] s2_pt_r;

  // Control state
  logic signed [AW-1:0] yaw_tgt_r, yaw_tgt_nxt;
  logic signed [AW-1:0] pitch_tgt_r, pitch_tgt_nxt;
  logic signed [AW-1:0] yaw_last_r, yaw_last_nxt;
  logic signed [AW-1:0] pitch_last_r, pitch_last_nxt;
  logic                 ysent_r, ysent_nxt;
  logic                 psent_r, psent_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 en_r, en_nxt;
  logic [IW-1:0]        idle_r, idle_nxt;
  logic [31:0]          nst_r, nst_nxt;
  logic [31:0]          lastseq_r, lastseq_nxt;

  logic                 ya_nxt, pa_nxt, stop_nxt;
  logic                 new_cmd, due, ymoved, pmoved;
  logic [IW-1:0]        idle_inc;
  logic [31:0]          since;
  logic signed [DW-1:0] ydiff, pdiff, ymag, pmag;
  logic [CNT_SUM_W-1:0] inflight;
  logic                 acc;

  // Reserve a queue slot for every tick in flight
  assign inflight = CNT_SUM_W'(q_count) + CNT_SUM_W'(s1_v_r) + CNT_SUM_W'(s2_v_r);
  assign in_ready = inflight < CNT_SUM_W'(QUEUE_DEPTH);
  assign acc      = in_valid && in_ready;

  // Stage 1: scale the deltas
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
    if (acc) begin
      s1_seq_r   <= in_seq;
      s1_known_r <= in_known;
      s1_ystep_r <= scale_round(in_yaw, YAW_MUL);
      s1_pstep_r <= scale_round(in_pitch, PITCH_MUL);
      s1_now_r   <= in_now;
    end
  end

  // Stage 2: advance the control state
  always_comb begin
    yaw_tgt_nxt    = yaw_tgt_r;
    pitch_tgt_nxt  = pitch_tgt_r;
    yaw_last_nxt   = yaw_last_r;
    pitch_last_nxt = pitch_last_r;
    ysent_nxt      = ysent_r;
    psent_nxt      = psent_r;
    stopped_nxt    = stopped_r;
    en_nxt         = en_r;
    idle_nxt       = idle_r;
    nst_nxt        = nst_r;
    lastseq_nxt    = lastseq_r;
    ya_nxt         = 1'b0;
    pa_nxt         = 1'b0;
    stop_nxt       = 1'b0;

    new_cmd  = (s1_seq_r != '0) && (s1_seq_r != lastseq_r);
    idle_inc = (&idle_r) ? idle_r : idle_r + IW'(1);
    since    = s1_now_r - nst_r;
    due      = !since[31];

    // new command or idle tick
    if (new_cmd) begin
      lastseq_nxt = s1_seq_r;
      idle_nxt    = '0;
      if (!s1_known_r) begin
        en_nxt = 1'b0;
      end else begin
        en_nxt        = 1'b1;
        yaw_tgt_nxt   = next_tgt(yaw_tgt_r, s1_ystep_r, cfg.yaw_limits);
        pitch_tgt_nxt = next_tgt(pitch_tgt_r, s1_pstep_r, cfg.pitch_limits);
      end
    end else begin
      idle_nxt = idle_inc;
      if (CW'(idle_inc) > CW'(cfg.idle_stop_ticks)) en_nxt = 1'b0;
    end

    ydiff  = DW'(yaw_tgt_nxt) - DW'(yaw_last_r);
    pdiff  = DW'(pitch_tgt_nxt) - DW'(pitch_last_r);
    ymag   = ydiff[DW-1] ? -ydiff : ydiff;
    pmag   = pdiff[DW-1] ? -pdiff : pdiff;
    ymoved = $unsigned(ymag) >= DW'(cfg.angle_epsilon);
    pmoved = $unsigned(pmag) >= DW'(cfg.angle_epsilon);

    // stop once when disabled, move rounds when enabled and due
    if (!en_nxt) begin
      if (!stopped_r) begin
        ya_nxt      = cfg.online_mask[0];
        pa_nxt      = cfg.online_mask[1];
        stop_nxt    = 1'b1;
        stopped_nxt = 1'b1;
        ysent_nxt   = 1'b0;
        psent_nxt   = 1'b0;
      end
    end else begin
      if (due) begin
        if (cfg.online_mask[0] && (!ysent_r || ymoved)) begin
          ya_nxt       = 1'b1;
          yaw_last_nxt = yaw_tgt_nxt;
          ysent_nxt    = 1'b1;
        end
        if (cfg.online_mask[1] && (!psent_r || pmoved)) begin
          pa_nxt         = 1'b1;
          pitch_last_nxt = pitch_tgt_nxt;
          psent_nxt      = 1'b1;
        end
        nst_nxt = s1_now_r + 32'(cfg.update_period_ms);
      end
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_tgt_r    <= '0;
      pitch_tgt_r  <= '0;
      yaw_last_r   <= '0;
      pitch_last_r <= '0;
      ysent_r      <= 1'b0;
      psent_r      <= 1'b0;
      stopped_r    <= 1'b0;
      en_r         <= 1'b0;
      idle_r       <= '0;
      nst_r        <= '0;
      lastseq_r    <= '0;
      s2_v_r       <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        yaw_tgt_r    <= yaw_tgt_nxt;
        pitch_tgt_r  <= pitch_tgt_nxt;
        yaw_last_r   <= yaw_last_nxt;
        pitch_last_r <= pitch_last_nxt;
        ysent_r      <= ysent_nxt;
        psent_r      <= psent_nxt;
        stopped_r    <= stopped_nxt;
        en_r         <= en_nxt;
        idle_r       <= idle_nxt;
        nst_r        <= nst_nxt;
        lastseq_r    <= lastseq_nxt;
      end
    end
    if (s1_v_r) begin
      s2_ya_r   <= ya_nxt;
      s2_pa_r   <= pa_nxt;
      s2_stop_r <= stop_nxt;
      s2_yt_r   <= yaw_tgt_nxt;
      s2_pt_r   <= pitch_tgt_nxt;
    end
  end

  // Stage 3: encode positions and queue the job
  assign push               = s2_v_r && (s2_ya_r || s2_pa_r);
  assign push_job.yaw_act   = s2_ya_r;
  assign push_job.pitch_act = s2_pa_r;
  assign push_job.is_stop   = s2_stop_r;
  assign push_job.yaw_raw   = raw_of(s2_yt_r, YAW_OFF);
  assign push_job.pitch_raw = raw_of(s2_pt_r, PITCH_OFF);

endmodule

FILE: rtl/gsfc_queue.sv
// Job queue between the front and back ends of the frame commander.
// Small register FIFO with a fill count; depends on gsfc_pkg.
module gsfc_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  gsfc_pkg::job_t              push_job,
  input  logic                        pop,
  output gsfc_pkg::job_t              head,
  output logic                        empty,
  output logic [gsfc_pkg::QCNT_W-1:0] count
);
  import gsfc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head  = slot_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  // Write at the tail, release at the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PTR_W'(1);
      if (pop) rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule

FILE: rtl/gsfc_back.sv
// Back end of the frame commander: serializes queued jobs into frame
// bytes behind an output register. Depends on gsfc_pkg.
module gsfc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  gsfc_pkg::cfg_t cfg,
  input  gsfc_pkg::job_t job,
  input  logic           job_empty,
  output logic           job_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_sel,
  output logic [7:0]     out_byte,
  output logic           out_frame_end,
  output logic           out_last
);
  import gsfc_pkg::*;

  logic [3:0] pos_r;
  logic       on_pitch_r;
  logic       out_v_r;
  logic       sel_r;
  logic [7:0] byte_r;
  logic       fend_r;
  logic       last_r;

  logic             cur_pitch, load, frame_end, tick_last;
  logic [7:0]       id, len, cmd, p0, p1, p2, p3, sum, chk, bval;
  logic [RAW_W-1:0] raw;
  logic [3:0]       end_pos;

  // Build the byte at the current frame position
  always_comb begin
    cur_pitch = on_pitch_r || !job.yaw_act;
    id        = cur_pitch ? cfg.servo_ids[15:8] : cfg.servo_ids[7:0];
    len       = job.is_stop ? LEN_STOP : LEN_MOVE;
    cmd       = job.is_stop ? CMD_STOP : CMD_MOVE;
    raw       = cur_pitch ? job.pitch_raw : job.yaw_raw;
    p0        = raw[7:0];
    p1        = 8'(raw[RAW_W-1:8]);
    p2        = cfg.move_time_ms[7:0];
    p3        = cfg.move_time_ms[15:8];
    sum       = id + len + cmd;
    if (!job.is_stop) sum = sum + p0 + p1 + p2 + p3;
    chk       = ~sum;
    end_pos   = job.is_stop ? POS_STOP_CHK : POS_MOVE_CHK;
    frame_end = (pos_r == end_pos);
    tick_last = frame_end && (cur_pitch || !job.pitch_act);
    case (pos_r)
      POS_HEAD0, POS_HEAD1: bval = FRAME_HEAD;
      POS_ID:               bval = id;
      POS_LEN:              bval = len;
      POS_CMD:              bval = cmd;
      POS_P0:               bval = job.is_stop ? chk : p0;
      POS_P1:               bval = p1;
      POS_P2:               bval = p2;
      POS_P3:               bval = p3;
      default:              bval = chk;
    endcase
  end

  assign load    = !job_empty && (!out_v_r || out_ready);
  assign job_pop = load && tick_last;

  // Advance through the frames of the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_HEAD0;
      on_pitch_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (load) begin
        out_v_r <= 1'b1;
        if (frame_end) begin
          pos_r      <= POS_HEAD0;
          on_pitch_r <= !tick_last;
        end else begin
          pos_r <= pos_r + 4'd1;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (load) begin
      sel_r  <= cur_pitch;
      byte_r <= bval;
      fend_r <= frame_end;
      last_r <= tick_last;
    end
  end

  assign out_valid     = out_v_r;
  assign out_sel       = sel_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fend_r;
  assign out_last      = last_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for gimbal_servo_frame_commander: drives control ticks and
// register writes, predicts every frame byte and compares it on the output stream.
// Depends on gsfc_pkg and the RTL top level only.
module testbench;
  import gsfc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic [31:0] seq;
    logic        known;
    logic [15:0] yaw_d;
    logic [15:0] pitch_d;
    logic [31:0] now;
  } tick_t;

  typedef struct packed {
    logic       sel;
    logic [7:0] data;
    logic       fend;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_SERVO_IDS;
  logic [31:0] cfg_data = '0;

  // Register mirror, reset values
  logic [15:0] bus_ids = 16'd513;
  logic [1:0]  online = 2'd0;
  logic [15:0] idle_limit = 16'd250;
  logic [14:0] min_change = 15'd32;
  logic [15:0] period_ms = 16'd20;
  logic [15:0] move_ms = 16'd20;
  logic [31:0] yaw_lim = 32'd503374336;
  logic [31:0] pitch_lim = 32'd377547136;

  // Commander state as predicted
  logic signed [15:0] yaw_aim = '0;
  logic signed [15:0] pitch_aim = '0;
  logic signed [15:0] yaw_sent_at = '0;
  logic signed [15:0] pitch_sent_at = '0;
  logic               yaw_primed = 1'b0;
  logic               pitch_primed = 1'b0;
  logic               halted = 1'b0;
  logic               driving = 1'b0;
  logic [15:0]        idle_ticks = '0;
  logic [31:0]        due_ms = '0;
  logic [31:0]        seq_seen = '0;

  tick_t       ticks_to_send[$];
  frame_byte_t tick_bytes[$];
  frame_byte_t frame_bytes_due[$];

  logic        steady = 1'b0;
  int          n_fail = 0;
  int          stall_cycles = 0;
  logic [31:0] seq_ctr = '0;
  logic [31:0] clock_ms = '0;

  gimbal_servo_frame_commander uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Delta times mul/5, rounded to nearest, halves away from zero
  function automatic int scaled_step(int d, int mul);
    int n;
    n = d * mul;
    if (n >= 0) return (n + 2) / 5;
    return -((-n + 2) / 5);
  endfunction

  // Push up to min, then down to max; reversed limits always give max
  function automatic logic signed [15:0] next_angle(logic signed [15:0] cur, int step,
                                                    logic [31:0] lim);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    int v;
    lo = lim[15:0];
    hi = lim[31:16];
    v = cur + step;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return 16'(v);
  endfunction

  // Servo position 0..1000 from a target angle plus the axis offset
  function automatic logic [15:0] servo_raw(logic signed [15:0] aim, int offset);
    int a;
    a = aim + offset;
    if (a < 0) a = 0;
    if (a > SERVO_MAX) a = SERVO_MAX;
    return 16'((50 * a + 384) / 768);
  endfunction

  function automatic logic far_enough(logic signed [15:0] aim, logic signed [15:0] sent);
    int d;
    d = aim - sent;
    if (d < 0) d = -d;
    return d >= int'(min_change);
  endfunction

  // Append one stop or move frame for a servo link to this tick's bytes
  function automatic void add_frame(logic sel, logic [7:0] id, logic is_move,
                                    logic [15:0] raw);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    frame_byte_t fb;
    body.push_back(FRAME_HEAD);
    body.push_back(FRAME_HEAD);
    body.push_back(id);
    body.push_back(is_move ? LEN_MOVE : LEN_STOP);
    body.push_back(is_move ? CMD_MOVE : CMD_STOP);
    if (is_move) begin
      body.push_back(raw[7:0]);
      body.push_back(raw[15:8]);
      body.push_back(move_ms[7:0]);
      body.push_back(move_ms[15:8]);
    end
    sum = 8'd0;
    for (int i = 2; i < body.size(); i++) sum = sum + body[i];
    body.push_back(~sum);
    foreach (body[i]) begin
      fb.sel = sel;
      fb.data = body[i];
      fb.fend = (i == body.size() - 1);
      fb.last = 1'b0;
      tick_bytes.push_back(fb);
    end
  endfunction

  // Advance the commander state by one tick and queue the frame bytes it sends
  function automatic void encode_tick(logic [95:0] word, logic known);
    logic [31:0]        seq;
    logic [31:0]        now;
    logic [31:0]        lag;
    logic signed [15:0] yd;
    logic signed [15:0] pd;
    frame_byte_t        fb;
    seq = word[31:0];
    yd = word[47:32];
    pd = word[63:48];
    now = word[95:64];
    tick_bytes.delete();
    if (seq != 32'd0 && seq != seq_seen) begin
      seq_seen = seq;
      idle_ticks = '0;
      if (!known) begin
        driving = 1'b0;
      end else begin
        driving = 1'b1;
        yaw_aim = next_angle(yaw_aim, scaled_step(int'(yd), int'(YAW_MUL)), yaw_lim);
        pitch_aim = next_angle(pitch_aim, scaled_step(int'(pd), int'(PITCH_MUL)), pitch_lim);
      end
    end else begin
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks > idle_limit) driving = 1'b0;
    end
    if (!driving) begin
      // Stop once per disable, even with no servo online
      if (!halted) begin
        if (online[0]) add_frame(1'b0, bus_ids[7:0], 1'b0, 16'd0);
        if (online[1]) add_frame(1'b1, bus_ids[15:8], 1'b0, 16'd0);
        halted = 1'b1;
        yaw_primed = 1'b0;
        pitch_primed = 1'b0;
      end
    end else begin
      lag = now - due_ms;
      if (!lag[31]) begin
        if (online[0] && (!yaw_primed || far_enough(yaw_aim, yaw_sent_at))) begin
          add_frame(1'b0, bus_ids[7:0], 1'b1, servo_raw(yaw_aim, YAW_OFFSET));
          yaw_sent_at = yaw_aim;
          yaw_primed = 1'b1;
        end
        if (online[1] && (!pitch_primed || far_enough(pitch_aim, pitch_sent_at))) begin
          add_frame(1'b1, bus_ids[15:8], 1'b1, servo_raw(pitch_aim, PITCH_OFFSET));
          pitch_sent_at = pitch_aim;
          pitch_primed = 1'b1;
        end
        due_ms = now + 32'(period_ms);
      end
      halted = 1'b0;
    end
    foreach (tick_bytes[i]) begin
      fb = tick_bytes[i];
      fb.last = (i == tick_bytes.size() - 1);
      frame_bytes_due.push_back(fb);
    end
  endfunction

  function automatic void queue_tick(logic [31:0] seq, logic known, logic [15:0] yd,
                                     logic [15:0] pd, logic [31:0] now);
    tick_t t;
    t.seq = seq;
    t.known = known;
    t.yaw_d = yd;
    t.pitch_d = pd;
    t.now = now;
    ticks_to_send.push_back(t);
  endfunction

  // Tick driver: predict on acceptance, then present the next item or idle
  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) encode_tick(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (ticks_to_send.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          nxt = ticks_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {nxt.now, nxt.pitch_d, nxt.yaw_d, nxt.seq};
          in_tuser <= nxt.known;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Frame byte monitor: compare each accepted byte with the oldest prediction
  always @(posedge clk) begin : watch_bytes
    frame_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("frame_byte: nothing expected, got %02h", out_tdata);
          n_fail++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_tuser[0] !== want.sel) begin
            $error("servo_select: expected %0d, got %0d", want.sel, out_tuser[0]);
            n_fail++;
          end
          if (out_tdata !== want.data) begin
            $error("frame_byte: expected %02h, got %02h", want.data, out_tdata);
            n_fail++;
          end
          if (out_tuser[1] !== want.fend) begin
            $error("frame_end: expected %0d, got %0d", want.fend, out_tuser[1]);
            n_fail++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_tlast);
            n_fail++;
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Watchdog: end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (!rst_n ||
        (in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SERVO_IDS:    bus_ids = val[15:0];
      REG_ONLINE_MASK:  online = val[1:0];
      REG_IDLE_STOP:    idle_limit = val[15:0];
      REG_ANGLE_EPS:    min_change = val[14:0];
      REG_UPDATE_PER:   period_ms = val[15:0];
      REG_MOVE_TIME:    move_ms = val[15:0];
      REG_YAW_LIMITS:   yaw_lim = val;
      REG_PITCH_LIMITS: pitch_lim = val;
      default: ;
    endcase
  endtask

  // Hold until every item is in and every byte is out, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (ticks_to_send.size() != 0 || in_tvalid || frame_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_setup();
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    int r;
    write_reg(REG_SERVO_IDS, $urandom);
    r = $urandom_range(9);
    write_reg(REG_ONLINE_MASK, {30'($urandom), (r == 0) ? 2'd0 : 2'($urandom_range(1, 3))});
    r = $urandom_range(9);
    write_reg(REG_IDLE_STOP, {16'($urandom), (r < 6) ? 16'($urandom_range(30)) :
                                             (r == 6) ? 16'd0 :
                                             (r == 7) ? 16'hFFFF : 16'($urandom_range(31, 400))});
    r = $urandom_range(9);
    write_reg(REG_ANGLE_EPS, {17'($urandom), (r < 6) ? 15'($urandom_range(200)) :
                                             (r == 6) ? 15'd0 :
                                             (r == 7) ? 15'h7FFF : 15'($urandom)});
    r = $urandom_range(9);
    write_reg(REG_UPDATE_PER, {16'($urandom), (r < 7) ? 16'($urandom_range(40)) :
                                              (r == 7) ? 16'd0 :
                                              (r == 8) ? 16'hFFFF : 16'($urandom)});
    write_reg(REG_MOVE_TIME, $urandom);
    for (int k = 0; k < 2; k++) begin
      r = $urandom_range(9);
      if (r < 7) begin
        lo = 16'(-int'($urandom_range(12000)));
        hi = 16'($urandom_range(12000));
      end else begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      write_reg((k == 0) ? REG_YAW_LIMITS : REG_PITCH_LIMITS, {hi, lo});
    end
  endtask

  // Mostly fresh known commands with advancing time; the rest idle and noise
  task automatic random_run(int count);
    logic [31:0] seq;
    logic        known;
    logic [15:0] yd;
    logic [15:0] pd;
    int          r;
    repeat (count) begin
      r = $urandom_range(99);
      known = 1'b1;
      if (r < 62 || (r >= 78 && r < 86)) begin
        seq_ctr = seq_ctr + 32'd1;
        if (seq_ctr == 32'd0) seq_ctr = 32'd1;
        seq = seq_ctr;
        if (r >= 78) known = 1'b0;
      end else if (r < 72) begin
        seq = seq_ctr;
        known = 1'($urandom);
      end else if (r < 78) begin
        seq = 32'd0;
        known = 1'($urandom);
      end else begin
        seq_ctr = $urandom;
        seq = seq_ctr;
      end
      if ($urandom_range(3) != 0) begin
        yd = 16'($urandom_range(800)) - 16'd400;
        pd = 16'($urandom_range(800)) - 16'd400;
      end else begin
        yd = 16'($urandom);
        pd = 16'($urandom);
      end
      if ($urandom_range(19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + 32'($urandom_range(5));
      queue_tick(seq, known, yd, pd, clock_ms);
    end
  endtask

  initial begin : run_test
    logic [31:0] fresh;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, nothing online: the stop is recorded with no bytes
    queue_tick(32'd0, 1'b0, 16'h0000, 16'h0000, 32'd0);
    queue_tick(32'd1, 1'b1, 16'h0064, 16'hFF9C, 32'd0);
    drain();

    write_reg(REG_SERVO_IDS, 32'h0000_1F07);
    write_reg(REG_ONLINE_MASK, 32'd3);
    write_reg(REG_IDLE_STOP, 32'd3);
    write_reg(REG_ANGLE_EPS, 32'd32);
    write_reg(REG_UPDATE_PER, 32'd20);
    write_reg(REG_MOVE_TIME, 32'h0000_0114);
    write_reg(REG_YAW_LIMITS, 32'd503374336);
    write_reg(REG_PITCH_LIMITS, 32'd377547136);
    // Extreme deltas, off-period tick, small change, idle run into disable
    queue_tick(32'd2, 1'b1, 16'h7FFF, 16'h8000, 32'd21);
    queue_tick(32'd3, 1'b1, 16'h8000, 16'h7FFF, 32'd30);
    queue_tick(32'd3, 1'b1, 16'h0000, 16'h0000, 32'd41);
    queue_tick(32'd4, 1'b1, 16'h0005, 16'hFFFB, 32'd61);
    queue_tick(32'd4, 1'b0, 16'h0000, 16'h0000, 32'd62);
    queue_tick(32'd0, 1'b1, 16'hFFFF, 16'hFFFF, 32'd63);
    queue_tick(32'd4, 1'b1, 16'h0000, 16'h0000, 32'd64);
    queue_tick(32'd4, 1'b1, 16'h0000, 16'h0000, 32'd65);
    queue_tick(32'd4, 1'b1, 16'h0000, 16'h0000, 32'd66);
    queue_tick(32'd5, 1'b0, 16'h1234, 16'h4321, 32'd67);
    // Wrapping send time: far behind, then exactly at the half-range edge
    queue_tick(32'd6, 1'b1, 16'h001B, 16'hFFE5, 32'hFFFF_FFF0);
    queue_tick(32'd7, 1'b1, 16'h0000, 16'h0000, 32'h8000_0050);
    queue_tick(32'd8, 1'b1, 16'h0002, 16'h0003, 32'hFFFF_FFFF);
    drain();

    // Same id on both links, epsilon zero, reversed and full-range limits
    write_reg(REG_SERVO_IDS, 32'h0000_5A5A);
    write_reg(REG_ANGLE_EPS, 32'd0);
    write_reg(REG_UPDATE_PER, 32'd0);
    write_reg(REG_MOVE_TIME, 32'h0000_FFFF);
    write_reg(REG_YAW_LIMITS, 32'hFC18_03E8);
    write_reg(REG_PITCH_LIMITS, 32'h7FFF_8000);
    write_reg(REG_IDLE_STOP, 32'h0000_FFFF);
    queue_tick(32'd9, 1'b1, 16'hFFFF, 16'h0001, 32'd0);
    queue_tick(32'd9, 1'b1, 16'h0000, 16'h0000, 32'd0);
    queue_tick(32'd10, 1'b1, 16'h7FFF, 16'h7FFF, 32'd0);
    queue_tick(32'hFFFF_FFFF, 1'b1, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
    drain();

    // Yaw only, no idle allowed, widest epsilon and period
    write_reg(REG_ONLINE_MASK, 32'd1);
    write_reg(REG_SERVO_IDS, 32'h0000_FF00);
    write_reg(REG_ANGLE_EPS, 32'h0000_7FFF);
    write_reg(REG_IDLE_STOP, 32'd0);
    write_reg(REG_UPDATE_PER, 32'h0000_FFFF);
    write_reg(REG_YAW_LIMITS, 32'h7FFF_8000);
    write_reg(REG_PITCH_LIMITS, 32'h8000_7FFF);
    queue_tick(32'd11, 1'b1, 16'h0064, 16'h0000, 32'd5);
    queue_tick(32'd11, 1'b1, 16'h0000, 16'h0000, 32'd6);
    queue_tick(32'd12, 1'b1, 16'h0000, 16'h0001, 32'd10);
    drain();

    // Pitch only, then nothing online
    write_reg(REG_ONLINE_MASK, 32'd2);
    queue_tick(32'd13, 1'b1, 16'h0000, 16'h0040, 32'd20);
    queue_tick(32'd13, 1'b1, 16'h0000, 16'h0000, 32'd21);
    drain();
    write_reg(REG_ONLINE_MASK, 32'd0);
    queue_tick(32'd14, 1'b1, 16'h0000, 16'h0000, 32'd22);
    queue_tick(32'd14, 1'b0, 16'h0000, 16'h0000, 32'd23);
    drain();

    // Random phases, each under fresh register settings
    seq_ctr = 32'd100;
    clock_ms = 32'd1000;
    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      steady <= (ph == 3);
      random_run(45);
      drain();
    end
    steady <= 1'b0;

    // Long idle run under a high limit, then lower the limit below the count
    write_reg(REG_ONLINE_MASK, 32'd3);
    write_reg(REG_IDLE_STOP, 32'd40);
    write_reg(REG_ANGLE_EPS, 32'h0000_7FFF);
    write_reg(REG_UPDATE_PER, 32'd1000);
    fresh = seq_seen + 32'd1;
    if (fresh == 32'd0) fresh = 32'd1;
    queue_tick(fresh, 1'b1, 16'h0040, 16'hFFC0, clock_ms);
    repeat (30) queue_tick(fresh, 1'b1, 16'h0000, 16'h0000, clock_ms);
    drain();
    write_reg(REG_IDLE_STOP, 32'd10);
    queue_tick(fresh, 1'b0, 16'h0000, 16'h0000, clock_ms);
    drain();

    if (n_fail == 0 && frame_bytes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
